/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/pfb_pkg.sv */
`default_nettype none

package pfb_pkg;

  localparam int COLUMNS    = 32;
  localparam int ROWS       = 32;
  localparam int STORE_SIZE = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  // limits for the range check, 17 bits so a 64k store still fits
  localparam logic [16:0] SIZE_LIM      = 17'(STORE_SIZE);
  localparam logic [16:0] SIZE_LIM_WORD = 17'(STORE_SIZE - 1);

  // reciprocal for offset / COLUMNS, result low by at most one
  localparam logic [15:0] RECIP = 16'(65536 / COLUMNS);
  localparam logic [ADDR_W-1:0] COL_A = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(STORE_SIZE - 1);

  localparam logic [15:0] BASE_RESET = 16'h0200;

  typedef enum logic [2:0] {
    FUNC_RD_BYTE = 3'd0,
    FUNC_WR_BYTE = 3'd1,
    FUNC_RD_WORD = 3'd2,
    FUNC_WR_WORD = 3'd3,
    FUNC_CLEAR   = 3'd4
  } pfb_func_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_RANGE = 2'd3
  } pfb_kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDLO,
    S_RDHI,
    S_QUO,
    S_REM,
    S_EMIT
  } pfb_state_t;

  typedef struct packed {
    pfb_kind_t   kind;
    logic [15:0] data;
    logic [4:0]  x;
    logic [4:0]  y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } pfb_result_t;

  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'h0: rgb = 24'h000000;
      4'h1: rgb = 24'hffffff;
      4'h2: rgb = 24'h880000;
      4'h3: rgb = 24'haaffee;
      4'h4: rgb = 24'hcc44cc;
      4'h5: rgb = 24'h00cc55;
      4'h6: rgb = 24'h0000aa;
      4'h7: rgb = 24'heeee77;
      4'h8: rgb = 24'hdd8855;
      4'h9: rgb = 24'h664400;
      4'ha: rgb = 24'hff7777;
      4'hb: rgb = 24'h333333;
      4'hc: rgb = 24'h777777;
      4'hd: rgb = 24'haaff66;
      4'he: rgb = 24'h0088ff;
      4'hf: rgb = 24'hbbbbbb;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

/* rtl/pfb_ram.sv */
`default_nettype none

module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/palette_framebuffer_device.sv */
`default_nettype none
// clear and out-of-range results come straight from idle, a byte read passes S_RDLO, a word
// read S_RDLO then S_RDHI, and each pixel of a write S_QUO, S_REM then S_EMIT
// busy drops as the last read or pixel strobe rises, so the next request goes in that cycle
// a pixel goes through one multiply-by-reciprocal pass; the receiver cannot stall
// reset and clear sweep the store one byte a cycle with busy high
// the base address register resets to 0x200 and is written whenever cfg_valid is high

module palette_framebuffer_device (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_func,
  input  wire logic [15:0] in_address,
  input  wire logic [15:0] in_write_data,
  output logic             out_valid,
  output logic [1:0]       out_result_kind,
  output logic [15:0]      out_read_data,
  output logic [4:0]       out_pixel_x,
  output logic [4:0]       out_pixel_y,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  import pfb_pkg::*;

  `include "assert_macros.svh"

  pfb_state_t         state_r, state_nxt;
  logic [15:0]        base_r;
  logic               is_word_r, is_word_nxt;
  logic               second_r, second_nxt;
  logic [ADDR_W-1:0]  off_r, off_nxt;
  logic [ADDR_W-1:0]  pix_off_r, pix_off_nxt;
  logic [3:0]         pix_val_r, pix_val_nxt;
  logic [7:0]         hi_r, hi_nxt;
  logic [7:0]         lo_r, lo_nxt;
  logic [ADDR_W-1:0]  q0_r, q0_nxt;
  logic [ADDR_W-1:0]  rem_r, rem_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               res_valid_r, res_valid_nxt;
  pfb_result_t        res_r, res_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [7:0]         ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;

  logic [16:0]        diff;
  logic               ok_byte;
  logic               ok_word;
  logic [ADDR_W-1:0]  in_off;
  logic [ADDR_W+15:0] prod;
  logic [ADDR_W-1:0]  qc;
  logic               fix;
  logic [ADDR_W-1:0]  x_full;
  logic [ADDR_W-1:0]  y_full;
  logic [23:0]        rgb;

  pfb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_SIZE)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign diff    = {1'b0, in_address} - {1'b0, base_r};
  assign ok_byte = !diff[16] && ({1'b0, diff[15:0]} < SIZE_LIM);
  assign ok_word = !diff[16] && ({1'b0, diff[15:0]} < SIZE_LIM_WORD);
  assign in_off  = diff[ADDR_W-1:0];

  assign prod   = (ADDR_W+16)'(pix_off_r) * (ADDR_W+16)'(RECIP);
  assign qc     = q0_r * COL_A;
  assign fix    = rem_r >= COL_A;
  assign x_full = fix ? rem_r - COL_A : rem_r;
  assign y_full = fix ? q0_r + 1'b1 : q0_r;
  assign rgb    = palette_rgb(pix_val_r);

  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    is_word_nxt   = is_word_r;
    second_nxt    = second_r;
    off_nxt       = off_r;
    pix_off_nxt   = pix_off_r;
    pix_val_nxt   = pix_val_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    q0_nxt        = q0_r;
    rem_nxt       = rem_r;
    clr_cnt_nxt   = clr_cnt_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = off_r;
    ram_wdata     = 8'h00;
    ram_raddr     = off_r;

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (pfb_func_t'(in_func))
            FUNC_RD_BYTE, FUNC_RD_WORD: begin
              is_word_nxt = pfb_func_t'(in_func) == FUNC_RD_WORD;
              if ((is_word_nxt && ok_word) || (!is_word_nxt && ok_byte)) begin
                ram_raddr = in_off;
                off_nxt   = in_off;
                state_nxt = S_RDLO;
              end else begin
                res_valid_nxt = 1'b1;
                res_nxt       = '0;
                res_nxt.kind  = KIND_RANGE;
                res_nxt.last  = 1'b1;
              end
            end
            FUNC_WR_BYTE, FUNC_WR_WORD: begin
              second_nxt = pfb_func_t'(in_func) == FUNC_WR_WORD;
              if ((second_nxt && ok_word) || (!second_nxt && ok_byte)) begin
                ram_we      = 1'b1;
                ram_waddr   = in_off;
                ram_wdata   = in_write_data[7:0];
                pix_off_nxt = in_off;
                pix_val_nxt = in_write_data[3:0];
                hi_nxt      = in_write_data[15:8];
                off_nxt     = in_off + 1'b1;
                state_nxt   = S_QUO;
              end else begin
                second_nxt    = 1'b0;
                res_valid_nxt = 1'b1;
                res_nxt       = '0;
                res_nxt.kind  = KIND_RANGE;
                res_nxt.last  = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              res_valid_nxt = 1'b1;
              res_nxt       = '0;
              res_nxt.kind  = KIND_CLEAR;
              res_nxt.last  = 1'b1;
              clr_cnt_nxt   = '0;
              state_nxt     = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_RDLO: begin
        if (is_word_r) begin
          lo_nxt    = ram_rdata;
          ram_raddr = off_r + 1'b1;
          state_nxt = S_RDHI;
        end else begin
          res_valid_nxt = 1'b1;
          res_nxt       = '0;
          res_nxt.kind  = KIND_READ;
          res_nxt.data  = {8'h00, ram_rdata};
          res_nxt.last  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RDHI: begin
        res_valid_nxt = 1'b1;
        res_nxt       = '0;
        res_nxt.kind  = KIND_READ;
        res_nxt.data  = {ram_rdata, lo_r};
        res_nxt.last  = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_QUO: begin
        q0_nxt    = prod[ADDR_W+15:16];
        state_nxt = S_REM;
      end
      S_REM: begin
        rem_nxt   = pix_off_r - qc;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        res_valid_nxt = 1'b1;
        res_nxt       = '0;
        res_nxt.kind  = KIND_PIXEL;
        res_nxt.x     = 5'(x_full);
        res_nxt.y     = 5'(y_full);
        res_nxt.red   = rgb[23:16];
        res_nxt.green = rgb[15:8];
        res_nxt.blue  = rgb[7:0];
        res_nxt.last  = !second_r;
        if (second_r) begin
          // high byte of a word write
          ram_we      = 1'b1;
          ram_waddr   = off_r;
          ram_wdata   = hi_r;
          pix_off_nxt = off_r;
          pix_val_nxt = hi_r[3:0];
          second_nxt  = 1'b0;
          state_nxt   = S_QUO;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      second_r    <= 1'b0;
      is_word_r   <= 1'b0;
      res_valid_r <= 1'b0;
      base_r      <= BASE_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      second_r    <= second_nxt;
      is_word_r   <= is_word_nxt;
      res_valid_r <= res_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r     <= off_nxt;
    pix_off_r <= pix_off_nxt;
    pix_val_r <= pix_val_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    q0_r      <= q0_nxt;
    rem_r     <= rem_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid       = res_valid_r;
  assign out_result_kind = res_r.kind;
  assign out_read_data   = res_r.data;
  assign out_pixel_x     = res_r.x;
  assign out_pixel_y     = res_r.y;
  assign out_red         = res_r.red;
  assign out_green       = res_r.green;
  assign out_blue        = res_r.blue;
  assign out_last        = res_r.last;

  // only the first pixel of a word write is not last
  `ASSERT_CLK(a_nonlast_pixel, clk, rst_n, (out_valid && !out_last) |-> (out_result_kind == KIND_PIXEL), "non-last result is not a pixel")

  // a second pixel is still pending after a non-last result
  `ASSERT_CLK(a_nonlast_busy, clk, rst_n, (out_valid && !out_last) |-> busy, "idle with second pixel pending")

  // clear request answers in the next cycle
  `ASSERT_CLK(a_clear_resp, clk, rst_n, (start && !busy && in_func == FUNC_CLEAR) |=> (out_valid && out_result_kind == KIND_CLEAR), "clear request not answered")

  // pixel fields are zero outside draw results
  `ASSERT_NEVER(a_pixel_zero, clk, rst_n, out_valid && out_result_kind != KIND_PIXEL && (out_pixel_x != 5'd0 || out_pixel_y != 5'd0 || out_red != 8'd0 || out_green != 8'd0 || out_blue != 8'd0), "pixel fields set on non-pixel result")

endmodule

`default_nettype wire
